// ----- hw/rtl/msd_pkg.sv -----
// Shared types, character codes and the Morse code tree lookup for the Morse stream decoder.
package msd_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned POS_W  = 7;
    localparam int unsigned GAP_W  = 3;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [GAP_W-1:0]  gap_t;

    localparam char_t CHAR_DOT     = 8'h2E;
    localparam char_t CHAR_DASH    = 8'h2D;
    localparam char_t CHAR_SPACE   = 8'h20;
    localparam char_t CHAR_NEWLINE = 8'h0A;
    localparam char_t CHAR_BLANK   = 8'h23;
    localparam char_t CHAR_NONE    = 8'h00;

    localparam pos_t POS_ROOT = 7'd1;
    localparam gap_t GAP_WORD = 3'd3;
    localparam gap_t GAP_MAX  = 3'd7;

    // One decoded result leaving the symbol decoder.
    typedef struct packed {
        logic  valid;
        char_t ch;
    } msd_result_t;

    // Tree node contents by heap position. CHAR_NONE marks a position with no node,
    // CHAR_BLANK an inner node that carries no character.
    function automatic char_t tree_char(input pos_t pos);
        char_t ch;
        unique case (pos)
            7'd1:    ch = CHAR_BLANK;
            7'd2:    ch = "E";
            7'd3:    ch = "T";
            7'd4:    ch = "I";
            7'd5:    ch = "A";
            7'd6:    ch = "N";
            7'd7:    ch = "M";
            7'd8:    ch = "S";
            7'd9:    ch = "U";
            7'd10:   ch = "R";
            7'd11:   ch = "W";
            7'd12:   ch = "D";
            7'd13:   ch = "K";
            7'd14:   ch = "G";
            7'd15:   ch = "O";
            7'd16:   ch = "H";
            7'd17:   ch = "V";
            7'd18:   ch = "F";
            7'd19:   ch = CHAR_BLANK;
            7'd20:   ch = "L";
            7'd21:   ch = CHAR_BLANK;
            7'd22:   ch = "P";
            7'd23:   ch = "J";
            7'd24:   ch = "B";
            7'd25:   ch = "X";
            7'd26:   ch = "C";
            7'd27:   ch = "Y";
            7'd28:   ch = "Z";
            7'd29:   ch = "Q";
            7'd30:   ch = CHAR_BLANK;
            7'd31:   ch = CHAR_BLANK;
            7'd32:   ch = "5";
            7'd33:   ch = "4";
            7'd35:   ch = "3";
            7'd38:   ch = CHAR_BLANK;
            7'd39:   ch = "2";
            7'd42:   ch = CHAR_BLANK;
            7'd47:   ch = "1";
            7'd48:   ch = "6";
            7'd53:   ch = CHAR_BLANK;
            7'd56:   ch = "7";
            7'd57:   ch = CHAR_BLANK;
            7'd60:   ch = "8";
            7'd62:   ch = "9";
            7'd63:   ch = "0";
            7'd76:   ch = "?";
            7'd85:   ch = ".";
            7'd94:   ch = 8'h27;
            7'd97:   ch = "-";
            7'd106:  ch = ";";
            7'd115:  ch = ",";
            7'd120:  ch = ":";
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

endpackage

// ----- hw/rtl/msd_if.sv -----
// Valid/ready stream interfaces for the text bytes in and the decoded characters out.
interface msd_text_if
    import msd_pkg::*;
();
    logic  valid;
    logic  ready;
    char_t in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

interface msd_decoded_if
    import msd_pkg::*;
();
    logic  valid;
    logic  ready;
    char_t out_char;

    modport source (output valid, output out_char, input ready);
    modport sink   (input valid, input out_char, output ready);
endinterface

// ----- hw/rtl/morse_stream_decoder.sv -----
// Top level of the Morse stream decoder: byte stream in, decoded characters out.
//
// The decoder takes one text byte per beat on the text channel and produces zero or one
// character per byte on the decoded channel. A dot or a dash walks the Morse code tree, a
// space or a newline ends the symbol and emits its character, and the third separator in
// a row emits a word space; every other byte is dropped without effect. The block accepts
// one byte in every cycle while the skid register is empty: the tree walk and the
// table lookup finish in the cycle of acceptance, and the result lands in the output
// register, or in the skid register while the sink stalls, on the same edge. A two-entry
// output stage (an output register and a skid register) decouples the channels, so
// text.ready depends only on registered state and a byte is still accepted while a
// finished character waits for the sink. A path that leaves the tree prints nothing for
// that symbol, and the decoder returns to the root at the next separator.
module morse_stream_decoder
    import msd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    msd_text_if.sink      text,
    msd_decoded_if.source decoded
);

    msd_result_t step_result;
    logic        text_fire;
    logic        out_free;

    logic  out_valid_reg, out_valid_next;
    char_t out_char_reg,  out_char_next;
    logic  skid_valid_reg, skid_valid_next;
    char_t skid_char_reg,  skid_char_next;

    // The skid register is the only thing that can stop the input side.
    assign text.ready = !skid_valid_reg;
    assign text_fire  = text.valid && text.ready;

    msd_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (text_fire),
        .in_char (text.in_char),
        .result  (step_result)
    );

    // The output register is free when it is empty or its beat is being taken now.
    assign out_free = !out_valid_reg || decoded.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        skid_valid_next = skid_valid_reg;
        skid_char_next  = skid_char_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // No byte is accepted while the skid register is full.
                out_valid_next  = 1'b1;
                out_char_next   = skid_char_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = text_fire && step_result.valid;
                out_char_next  = step_result.ch;
            end
        end
        else if (text_fire && step_result.valid)
        begin
            skid_valid_next = 1'b1;
            skid_char_next  = step_result.ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        skid_char_reg <= skid_char_next;
    end

    assign decoded.valid    = out_valid_reg;
    assign decoded.out_char = out_char_reg;

endmodule

// ----- hw/rtl/msd_step.sv -----
// Symbol decoder: tree position, off-tree flag and separator counter, one byte per beat.
module msd_step
    import msd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  char_t       in_char,
    output msd_result_t result
);

    pos_t pos_reg, pos_next;
    logic off_reg, off_next;
    gap_t gap_reg, gap_next;

    pos_t  child;
    char_t here;
    logic  is_sep;
    logic  is_move;

    always_comb
    begin
        is_sep   = (in_char == CHAR_SPACE) || (in_char == CHAR_NEWLINE);
        is_move  = (in_char == CHAR_DOT) || (in_char == CHAR_DASH);
        here     = tree_char(pos_reg);
        child    = {pos_reg[POS_W-2:0], (in_char == CHAR_DASH)};
        pos_next = pos_reg;
        off_next = off_reg;
        gap_next = gap_reg;
        result   = '{valid: 1'b0, ch: here};

        if (is_sep)
        begin
            if (gap_reg != GAP_MAX)
            begin
                gap_next = gap_reg + gap_t'(1);
            end
            if (!off_reg)
            begin
                if (here != CHAR_NONE && here != CHAR_BLANK)
                begin
                    result.valid = 1'b1;
                end
                else if (gap_next == GAP_WORD)
                begin
                    result.valid = 1'b1;
                    result.ch    = CHAR_SPACE;
                end
            end
            pos_next = POS_ROOT;
            off_next = 1'b0;
        end
        else if (is_move)
        begin
            gap_next = '0;
            if (!off_reg)
            begin
                // A seventh symbol or a missing node leaves the tree.
                if (pos_reg[POS_W-1] || tree_char(child) == CHAR_NONE)
                begin
                    off_next = 1'b1;
                end
                else
                begin
                    pos_next = child;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_ROOT;
            off_reg <= 1'b0;
            gap_reg <= '0;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
            off_reg <= off_next;
            gap_reg <= gap_next;
        end
    end

endmodule

// ----- hw/rtl/msd_checker.sv -----
// Port-level assertions for the Morse stream decoder and the bind that attaches them.
module msd_checker
    import msd_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  text_valid,
    input logic  text_ready,
    input char_t in_char,
    input logic  decoded_valid,
    input logic  decoded_ready,
    input char_t out_char
);

    logic text_fire;
    logic is_sep;

    assign text_fire = text_valid && text_ready;
    assign is_sep    = (in_char == CHAR_SPACE) || (in_char == CHAR_NEWLINE);

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        decoded_valid && !decoded_ready |=> decoded_valid && $stable(out_char))
    else $error("decoded beat changed while stalled");

    // Only a separator can produce a result: with the output empty, any other byte leaves it empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        text_fire && !is_sep && !decoded_valid |=> !decoded_valid)
    else $error("result produced by a byte that is not a separator");

    // Blank inner nodes and missing nodes never reach the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        decoded_valid |-> out_char != CHAR_BLANK && out_char != CHAR_NONE)
    else $error("blank or missing tree node emitted");

    // Input back-pressure only arises with a result already waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !text_ready |-> decoded_valid)
    else $error("input stalled with an empty output");

endmodule

bind morse_stream_decoder msd_checker u_msd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .text_valid    (text.valid),
    .text_ready    (text.ready),
    .in_char       (text.in_char),
    .decoded_valid (decoded.valid),
    .decoded_ready (decoded.ready),
    .out_char      (decoded.out_char)
);

// ----- tb/morse_stream_decoder_tb.sv -----
// Self-checking testbench for the Morse stream decoder with a scoreboard class and stream drivers.
module morse_stream_decoder_tb
    import msd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The watchdog ends the run after this many cycles without a beat on either channel.
    // The longest legal quiet stretch is the receiver hold-off below, so this leaves a
    // wide margin over it.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_BEATS    = 530;
    localparam int DRAIN_CYCLES   = 8;

    // Morse code book: first character is the decoded symbol, the rest is its code.
    // A leading '#' marks an inner node that carries no character; the lone '#' is the root.
    string code_book[$] = '{
        "#", "E.", "T-", "I..", "A.-", "N-.", "M--", "S...", "U..-", "R.-.", "W.--",
        "D-..", "K-.-", "G--.", "O---", "H....", "V...-", "F..-.", "#..--", "L.-..",
        "#.-.-", "P.--.", "J.---", "B-...", "X-..-", "C-.-.", "Y-.--", "Z--..", "Q--.-",
        "#---.", "#----", "5.....", "4....-", "3...--", "#..--.", "2..---", "#.-.-.",
        "1.----", "6-....", "#-.-.-", "7--...", "#--..-", "8---..", "9----.", "0-----",
        "?..--..", "..-.-.-", "'.----.", "--....-", ";-.-.-.", ",--..--", ":---..."
    };

    // Predicts the decoded characters from the accepted text beats and checks the
    // characters that come out against them in order.
    class decode_checker;
        char_t node_char[128];
        pos_t  position;
        bit    lost;
        gap_t  sep_run;
        char_t expected_chars[$];
        int    errors;

        function new(string book[$]);
            int p;
            foreach (node_char[i]) node_char[i] = CHAR_NONE;
            foreach (book[i])
            begin
                p = 1;
                for (int k = 1; k < book[i].len(); k++)
                    p = 2 * p + ((book[i][k] == CHAR_DASH) ? 1 : 0);
                node_char[p] = book[i][0];
            end
            position = POS_ROOT;
            lost     = 1'b0;
            sep_run  = '0;
            errors   = 0;
        endfunction

        function void note_byte(char_t c);
            logic [POS_W:0] next_pos;
            char_t          here;
            if (c == CHAR_SPACE || c == CHAR_NEWLINE)
            begin
                if (sep_run != GAP_MAX)
                    sep_run++;
                if (!lost)
                begin
                    here = node_char[position];
                    if (here != CHAR_NONE && here != CHAR_BLANK)
                        expected_chars.push_back(here);
                    else if (sep_run == GAP_WORD)
                        expected_chars.push_back(CHAR_SPACE);
                end
                position = POS_ROOT;
                lost     = 1'b0;
            end
            else if (c == CHAR_DOT || c == CHAR_DASH)
            begin
                sep_run = '0;
                if (!lost)
                begin
                    next_pos = {position, c == CHAR_DASH};
                    // Stepping past depth six or onto an empty slot leaves the tree.
                    if (next_pos[POS_W] || node_char[next_pos[POS_W-1:0]] == CHAR_NONE)
                        lost = 1'b1;
                    else
                        position = next_pos[POS_W-1:0];
                end
            end
        endfunction

        function void check_char(char_t got);
            char_t want;
            if (expected_chars.size() == 0)
            begin
                $error("out_char: expected none, actual 0x%02h", got);
                errors++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (got !== want)
                begin
                    $error("out_char: expected 0x%02h, actual 0x%02h", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    msd_text_if    text_if ();
    msd_decoded_if dec_if ();

    morse_stream_decoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_if.sink),
        .decoded (dec_if.source)
    );

    decode_checker checker_h;

    int tx_idle_pct;
    int rx_idle_pct;
    int symbol_beats;
    int quiet_cycles;
    bit hold_go;
    bit hold_rx;

    // 10 ns clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every input of the block starts at a known value before the first edge.
    initial
    begin
        checker_h       = new(code_book);
        rst_n           = 1'b0;
        text_if.valid   = 1'b0;
        text_if.in_char = '0;
        dec_if.ready    = 1'b0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        symbol_beats    = 0;
        hold_go         = 1'b0;
        hold_rx         = 1'b0;
    end

    function automatic bit is_symbol_byte(char_t c);
        return c == CHAR_DOT || c == CHAR_DASH || c == CHAR_SPACE || c == CHAR_NEWLINE;
    endfunction

    // Offers one byte on the text channel and returns once the beat is taken. Valid is
    // only dropped while the sender idles, so back-to-back beats keep it high.
    task automatic send_byte(input char_t c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            text_if.valid <= 1'b0;
            @(posedge clk);
        end
        text_if.valid   <= 1'b1;
        text_if.in_char <= c;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        checker_h.note_byte(c);
        if (is_symbol_byte(c))
            symbol_beats++;
    endtask

    // A well-formed symbol from the code book, sometimes with a stray byte in the middle,
    // followed by a run of separators. The longest runs push the separator count to saturation.
    task automatic send_symbol();
        string code;
        int    n_sep;
        code = code_book[$urandom_range(code_book.size() - 1)];
        for (int k = 1; k < code.len(); k++)
        begin
            if ($urandom_range(99) < 5)
                send_byte(char_t'($urandom_range(255)));
            send_byte(char_t'(code[k]));
        end
        n_sep = ($urandom_range(99) < 12) ? $urandom_range(9, 4) : $urandom_range(3, 1);
        repeat (n_sep)
            send_byte($urandom_range(1) ? CHAR_SPACE : CHAR_NEWLINE);
    endtask

    // A random walk of dots and dashes that is often too long or off the tree.
    task automatic send_broken();
        repeat ($urandom_range(8, 1))
            send_byte($urandom_range(1) ? CHAR_DASH : CHAR_DOT);
        send_byte($urandom_range(1) ? CHAR_SPACE : CHAR_NEWLINE);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        int target;
        int pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target      = symbol_beats + PHASE_BEATS;
        while (symbol_beats < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_symbol();
            else if (pick < 85)
                send_broken();
            else
                send_byte(char_t'($urandom_range(255)));
        end
    endtask

    // Receiver: checks the beat taken at this edge, then picks ready for the next cycle.
    // The long hold-off overrides the random stalls.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dec_if.valid && dec_if.ready)
                checker_h.check_char(dec_if.out_char);
            dec_if.ready <= hold_rx ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // The receiver stops for a long stretch while the sender keeps offering bytes, so
    // the output stage fills up and the decoder has to stall the text channel.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((text_if.valid && text_if.ready) || (dec_if.valid && dec_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        string opening;
        quiet_cycles = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: bytes at both ends of the range that are ignored, a six-symbol
        // code, a separator on an inner node without a character, the word space on the
        // third separator and silence on the fourth, and a path that leaves the tree,
        // keeps taking dashes and then prints nothing at the newline.
        send_byte(8'h00);
        send_byte(8'hFF);
        opening = "..--..\n.-.-\n \n ---.--\n";
        for (int i = 0; i < opening.len(); i++)
            send_byte(char_t'(opening[i]));

        run_phase(22, 68);
        run_phase(68, 22);
        hold_go = 1'b1;
        run_phase(0, 0);

        text_if.valid <= 1'b0;
        while (checker_h.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (checker_h.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
